/* rtl/core/octu_pkg.sv */
// Shared types and constants for the ordered completion table unit.
// Used by octu_ctrl, octu_dp and ordered_completion_table_unit; depends on nothing.
package octu_pkg;

	localparam int SLOTS  = 16;
	localparam int IDX_W  = 4;
	localparam int KEY_W  = 32;
	localparam int SEQ_W  = 64;
	localparam int KIND_W = 3;
	localparam int STAT_W = 2;
	localparam int SU_W   = 5;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	// Operation kinds.
	localparam logic [KIND_W-1:0] KIND_RECORD = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SELECT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_WAKE   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_WAIT   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FAULT  = 3'd4;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_INVARG   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_INVSTATE = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

	// Slot states.
	localparam logic [1:0] SLOT_FREE      = 2'd0;
	localparam logic [1:0] SLOT_PENDING   = 2'd1;
	localparam logic [1:0] SLOT_DELIVERED = 2'd2;

	// Register indexes (paddr bit 2).
	localparam logic REG_ENABLED = 1'b0;
	localparam logic REG_SLOTS   = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic scan_start;
		logic scan_step;
		logic commit;
		logic load_out;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_scan;
		logic at_end;
	} dp_stat_t;

endpackage

/* rtl/core/ordered_completion_table_unit.sv */
// Top level of the ordered completion table: register port, controller and datapath.
// Depends on octu_pkg, octu_ctrl and octu_dp.
//
// The unit keeps sixteen completion slots, each holding a nonzero key, a sequence
// number and a state (free, pending or delivered). One operation item goes in per
// transfer and exactly one result comes out per item, in order: record fills the lowest
// free slot, select names the oldest pending slot, wake report delivers or frees that
// slot, wait done frees the first delivered slot with the key, and fault read returns
// and clears the sticky full fault. Items are processed one at a time by a controller
// that walks the key and sequence memories one slot per clock. An item is accepted
// only while the unit is idle. Operations that need no scan (rejected items and
// fault read) go straight to commit, a wake report scans only its named slot, and
// record, select and wait done scan the first slots_searched slots, where
// slots_searched is the slots_in_use register clamped to 1..16. A finished result sits
// in an output register, so the next item is taken while it waits to be transferred.
// Register 0 (enabled, byte address 0) binds the table; any write that changes its
// value empties all slots and clears the sequence counter and the fault. Register 1
// (slots_in_use, byte address 4) limits the search and takes effect at once.
// Configuration must only be written while no item is in flight.
module ordered_completion_table_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [octu_pkg::ADDR_W-1:0]   paddr,
	input  logic [octu_pkg::DATA_W-1:0]   pwdata,
	output logic [octu_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [octu_pkg::KIND_W-1:0]   kind,
	input  logic [octu_pkg::KEY_W-1:0]    key,
	input  logic [octu_pkg::IDX_W-1:0]    slot_index,
	input  logic                          woken,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [octu_pkg::STAT_W-1:0]   status,
	output logic                          found,
	output logic [octu_pkg::IDX_W-1:0]    chosen_slot,
	output logic [octu_pkg::KEY_W-1:0]    chosen_key,
	output logic                          fault_seen,
	output logic                          any_pending
);
	import octu_pkg::*;

	logic            enabled_q;
	logic [SU_W-1:0] slots_in_use_q;
	logic            cfg_wr;
	logic            tbl_clear;
	ctl_cmd_t        cmd;
	dp_stat_t        stat;

	// The register port never waits. Bit 2 of the address picks the register.
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite;
	assign tbl_clear = cfg_wr && paddr[2] == REG_ENABLED && pwdata[0] != enabled_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q      <= 1'b0;
			slots_in_use_q <= SU_W'(SLOTS);
		end else if (cfg_wr) begin
			if (paddr[2] == REG_ENABLED) enabled_q <= pwdata[0];
			else slots_in_use_q <= pwdata[SU_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_SLOTS) prdata = {{(DATA_W-SU_W){1'b0}}, slots_in_use_q};
		else prdata = {{(DATA_W-1){1'b0}}, enabled_q};
	end

	octu_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.stat         (stat)
	);

	octu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.enabled      (enabled_q),
		.slots_in_use (slots_in_use_q),
		.tbl_clear    (tbl_clear),
		.kind         (kind),
		.key          (key),
		.slot_index   (slot_index),
		.woken        (woken),
		.status       (status),
		.found        (found),
		.chosen_slot  (chosen_slot),
		.chosen_key   (chosen_key),
		.fault_seen   (fault_seen),
		.any_pending  (any_pending)
	);

endmodule

/* rtl/core/octu_dp.sv */
// Datapath of the ordered completion table: item registers, slot memories,
// scan trackers, table state and the result register. Depends on octu_pkg.
module octu_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  octu_pkg::ctl_cmd_t           cmd,
	output octu_pkg::dp_stat_t           stat,
	input  logic                         enabled,
	input  logic [octu_pkg::SU_W-1:0]    slots_in_use,
	input  logic                         tbl_clear,
	input  logic [octu_pkg::KIND_W-1:0]  kind,
	input  logic [octu_pkg::KEY_W-1:0]   key,
	input  logic [octu_pkg::IDX_W-1:0]   slot_index,
	input  logic                         woken,
	output logic [octu_pkg::STAT_W-1:0]  status,
	output logic                         found,
	output logic [octu_pkg::IDX_W-1:0]   chosen_slot,
	output logic [octu_pkg::KEY_W-1:0]   chosen_key,
	output logic                         fault_seen,
	output logic                         any_pending
);
	import octu_pkg::*;

	localparam logic [1:0] CLS_IMM   = 2'd0;
	localparam logic [1:0] CLS_SCAN  = 2'd1;
	localparam logic [1:0] CLS_FAULT = 2'd2;

	logic [KIND_W-1:0] kind_q;
	logic [KEY_W-1:0]  key_q;
	logic [IDX_W-1:0]  sidx_q;
	logic              woken_q;

	logic [KEY_W-1:0]  key_mem [SLOTS];
	logic [SEQ_W-1:0]  seq_mem [SLOTS];
	logic [1:0]        slot_st_q [SLOTS];
	logic [SEQ_W-1:0]  seq_ctr_q;
	logic              fault_q;

	logic [IDX_W-1:0]  n_last;
	logic [1:0]        cls;
	logic [STAT_W-1:0] imm_status;
	logic [IDX_W-1:0]  scan_first;
	logic [IDX_W-1:0]  scan_last;
	logic [IDX_W-1:0]  idx_q;

	logic [KEY_W-1:0]  key_rd_s1;
	logic [SEQ_W-1:0]  seq_rd_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              eval_s1;

	logic [1:0]        ev_st;
	logic              ev_keq;
	logic              ev_hit;

	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic              free_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic              found_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [SEQ_W-1:0]  best_seq_q;
	logic [KEY_W-1:0]  best_key_q;

	logic [SEQ_W-1:0]  seq_next;
	logic              mem_we;
	logic              pend_c;

	logic [STAT_W-1:0] res_status;
	logic              res_found;
	logic [IDX_W-1:0]  res_slot;
	logic [KEY_W-1:0]  res_key;
	logic              res_fseen;
	logic [STAT_W-1:0] res_status_q;
	logic              res_found_q;
	logic [IDX_W-1:0]  res_slot_q;
	logic [KEY_W-1:0]  res_key_q;
	logic              res_fseen_q;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q  <= kind;
			key_q   <= key;
			sidx_q  <= slot_index;
			woken_q <= woken;
		end
	end

	// Last searched index: zero searches one slot, large values clamp to the table.
	always_comb begin
		if (slots_in_use == '0) begin
			n_last = '0;
		end else if (slots_in_use > SU_W'(SLOTS)) begin
			n_last = IDX_W'(SLOTS - 1);
		end else begin
			n_last = IDX_W'(slots_in_use - SU_W'(1));
		end
	end

	always_comb begin
		cls        = CLS_IMM;
		imm_status = STAT_OK;
		if (kind_q > KIND_FAULT) begin
			imm_status = STAT_INVARG;
		end else if (kind_q == KIND_RECORD && key_q == '0) begin
			imm_status = STAT_INVARG;
		end else if (!enabled) begin
			imm_status = STAT_INVSTATE;
		end else begin
			case (kind_q)
				KIND_RECORD, KIND_SELECT: cls = CLS_SCAN;
				KIND_WAKE: begin
					if (sidx_q > n_last) imm_status = STAT_INVARG;
					else cls = CLS_SCAN;
				end
				KIND_WAIT: begin
					if (key_q == '0) imm_status = STAT_INVSTATE;
					else cls = CLS_SCAN;
				end
				KIND_FAULT: cls = CLS_FAULT;
				default: cls = CLS_IMM;
			endcase
		end
	end

	// A wake report looks at its one named slot; the other scans cover the searched range.
	assign scan_first     = (kind_q == KIND_WAKE) ? sidx_q : '0;
	assign scan_last      = (kind_q == KIND_WAKE) ? sidx_q : n_last;
	assign stat.need_scan = (cls == CLS_SCAN);
	assign stat.at_end    = (idx_q == scan_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.scan_start) begin
			idx_q <= scan_first;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			key_rd_s1 <= key_mem[idx_q];
			seq_rd_s1 <= seq_mem[idx_q];
			idx_s1    <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_s1 <= 1'b0;
		end else begin
			eval_s1 <= cmd.scan_step;
		end
	end

	assign seq_next = seq_ctr_q + SEQ_W'(1);
	assign mem_we   = cmd.commit && cls == CLS_SCAN && kind_q == KIND_RECORD && !hit_q && free_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[free_idx_q] <= key_q;
			seq_mem[free_idx_q] <= seq_next;
		end
	end

	assign ev_st  = slot_st_q[idx_s1];
	assign ev_keq = (key_rd_s1 == key_q);

	always_comb begin
		case (kind_q)
			KIND_RECORD: ev_hit = (ev_st != SLOT_FREE) && ev_keq;
			KIND_WAKE:   ev_hit = (ev_st == SLOT_PENDING) && ev_keq;
			KIND_WAIT:   ev_hit = (ev_st == SLOT_DELIVERED) && ev_keq;
			default:     ev_hit = 1'b0;
		endcase
	end

	// Trackers keep the first match, the first free slot and the oldest pending slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
			found_q    <= 1'b0;
			best_idx_q <= '0;
			best_seq_q <= '0;
			best_key_q <= '0;
		end else if (cmd.scan_start) begin
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			found_q <= 1'b0;
		end else if (eval_s1) begin
			if (ev_hit && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_s1;
			end
			if (ev_st == SLOT_FREE && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_s1;
			end
			if (ev_st == SLOT_PENDING && (!found_q || seq_rd_s1 < best_seq_q)) begin
				found_q    <= 1'b1;
				best_idx_q <= idx_s1;
				best_seq_q <= seq_rd_s1;
				best_key_q <= key_rd_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) slot_st_q[i] <= SLOT_FREE;
			seq_ctr_q <= '0;
			fault_q   <= 1'b0;
		end else if (tbl_clear) begin
			for (int i = 0; i < SLOTS; i++) slot_st_q[i] <= SLOT_FREE;
			seq_ctr_q <= '0;
			fault_q   <= 1'b0;
		end else if (cmd.commit) begin
			if (cls == CLS_SCAN) begin
				case (kind_q)
					KIND_RECORD: begin
						if (!hit_q) begin
							if (free_q) begin
								seq_ctr_q              <= seq_next;
								slot_st_q[free_idx_q]  <= SLOT_PENDING;
							end else begin
								fault_q <= 1'b1;
							end
						end
					end
					KIND_WAKE: begin
						if (hit_q) slot_st_q[sidx_q] <= woken_q ? SLOT_DELIVERED : SLOT_FREE;
					end
					KIND_WAIT: begin
						if (hit_q) slot_st_q[hit_idx_q] <= SLOT_FREE;
					end
					default: ;
				endcase
			end else if (cls == CLS_FAULT) begin
				fault_q <= 1'b0;
			end
		end
	end

	always_comb begin
		res_status = imm_status;
		if (cls == CLS_SCAN) begin
			res_status = (kind_q == KIND_RECORD && !hit_q && !free_q) ? STAT_FULL : STAT_OK;
		end else if (cls == CLS_FAULT) begin
			res_status = fault_q ? STAT_FULL : STAT_OK;
		end
		res_found = (cls == CLS_SCAN) && (kind_q == KIND_SELECT) && found_q;
		res_slot  = res_found ? best_idx_q : '0;
		res_key   = res_found ? best_key_q : '0;
		res_fseen = (cls == CLS_FAULT) && fault_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_status_q <= res_status;
			res_found_q  <= res_found;
			res_slot_q   <= res_slot;
			res_key_q    <= res_key;
			res_fseen_q  <= res_fseen;
		end
	end

	always_comb begin
		pend_c = fault_q;
		for (int i = 0; i < SLOTS; i++) begin
			if (enabled && slot_st_q[i] == SLOT_PENDING && IDX_W'(i) <= n_last) pend_c = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status      <= res_status_q;
			found       <= res_found_q;
			chosen_slot <= res_slot_q;
			chosen_key  <= res_key_q;
			fault_seen  <= res_fseen_q;
			any_pending <= pend_c;
		end
	end

	a_commit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !eval_s1)
		else $error("commit while a scan read is still being evaluated");

	a_fault_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out && fault_q) |=> any_pending)
		else $error("result with full fault set does not report pending");

	a_full_sets_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && res_status == STAT_FULL && cls == CLS_SCAN) |=> fault_q)
		else $error("full record did not set the fault");

endmodule

/* rtl/core/octu_ctrl.sv */
// Controller state machine of the ordered completion table: sequences the
// item handshake, the slot scan, the commit and the result register. Depends on octu_pkg.
module octu_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	output logic               result_valid,
	input  logic               result_stall,
	output octu_pkg::ctl_cmd_t cmd,
	input  octu_pkg::dp_stat_t stat
);
	import octu_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_LAST   = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;
	localparam logic [2:0] S_RESULT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       result_valid_q;

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = result_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.need_scan) begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end else begin
					state_d = S_COMMIT;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.at_end) state_d = S_LAST;
			end
			S_LAST: state_d = S_COMMIT;
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_RESULT;
			end
			S_RESULT: begin
				if (!result_valid_q || !result_stall) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;
		end
	end

	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> state_q == S_CHECK)
		else $error("accepted item did not enter the check state");

	a_rise_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q) == S_RESULT)
		else $error("result appeared outside the result state");

	a_hold_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT && result_valid && result_stall) |=> state_q == S_RESULT)
		else $error("new result dropped while the previous one was stalled");

endmodule
